// ===== hdl/ect_pkg.sv =====
// Shared types and constants for the event control table.
package ect_pkg;

  localparam int unsigned EventSlotsDef = 16;
  localparam int unsigned SlotSelW      = 4;   // handle bits that select a slot

  localparam logic [31:0] HandleBase       = 32'hF100_0000;
  localparam logic [31:0] MarkMode         = 32'h0000_2000;
  localparam logic [31:0] AlwaysReadyReset = 32'hF000_0009;

  localparam logic [2:0] FUNC_OPEN    = 3'd0;
  localparam logic [2:0] FUNC_CLOSE   = 3'd1;
  localparam logic [2:0] FUNC_ENABLE  = 3'd2;
  localparam logic [2:0] FUNC_DELIVER = 3'd3;
  localparam logic [2:0] FUNC_TEST    = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] event_ref;
    logic [31:0] event_class;
    logic [31:0] event_spec;
    logic [31:0] event_mode;
    logic [31:0] handler_addr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] event_handle;
    logic        table_full;
    logic        ready_flag;
    logic        call_handler;
    logic [31:0] handler_out;
    logic        delivered;
    logic        last;
  } out_item_t;

endpackage

// ===== hdl/ect_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ect_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/event_control_table.sv =====
// Event control table: slot store, operation sequencer and result register.
// Open scans slot flags one per cycle.
// Deliver reads one slot per cycle from the RAM through one shared compare,
// except while a callback result waits for a stalled result register.
// One item is in work at a time.
// Reset clears slot flags and sets the config register to AlwaysReadyReset at once; no clearing pass.
module event_control_table #(
  parameter int unsigned EVENT_SLOTS = ect_pkg::EventSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ect_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ect_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import ect_pkg::*;

  localparam int unsigned AW   = $clog2(EVENT_SLOTS);
  localparam int unsigned CW   = $clog2(EVENT_SLOTS + 1);
  localparam int unsigned RamW = 96;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_OPEN, S_DLV, S_DFIN, S_TEST
  } state_e;

  typedef enum logic [1:0] {
    ST_FREE, ST_DISABLED, ST_ENABLED
  } status_e;

  state_e    state_q, state_d;
  in_item_t  req_q, req_d;
  logic [AW-1:0] slot_q, slot_d;
  logic      inrange_q, inrange_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic      pend_q, pend_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic      any_q, any_d;
  logic [31:0] cfg_q;

  status_e   status_q [EVENT_SLOTS];
  status_e   status_d [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] mark_q, mark_d;
  logic [EVENT_SLOTS-1:0] ready_q, ready_d;
  logic [EVENT_SLOTS-1:0] written_q, written_d;

  out_item_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  logic            in_accept;
  logic            out_free;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [RamW-1:0] ram_wdata;
  logic [RamW-1:0] ram_rdata;

  logic [AW-1:0] rd_slot;
  logic [31:0]   rd_class;
  logic [31:0]   cmp_ref;
  logic          class_eq;
  logic          spec_eq;
  logic          dlv_hit;
  logic          dlv_go;
  logic [AW-1:0] cnt_slot;
  logic [AW-1:0] in_slot;
  logic          in_inrange;
  out_item_t     res;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_vld_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cnt_slot   = cnt_q[AW-1:0];
  assign in_slot    = AW'(in_data_i.event_ref[SlotSelW-1:0]);
  assign in_inrange = 32'(in_data_i.event_ref[SlotSelW-1:0]) < 32'(EVENT_SLOTS);

  // Slot whose RAM word is on the read port this cycle
  assign rd_slot  = (state_q == S_DLV) ? pidx_q : slot_q;
  assign rd_class = written_q[rd_slot] ? ram_rdata[95:64] : 32'd0;

  // Shared class comparator: config class for test, item class for deliver
  assign cmp_ref  = (state_q == S_TEST) ? cfg_q : req_q.event_class;
  assign class_eq = (rd_class == cmp_ref);
  assign spec_eq  = (ram_rdata[63:32] == req_q.event_spec);

  assign dlv_hit = pend_q && (status_q[pidx_q] == ST_ENABLED) && class_eq && spec_eq;
  assign dlv_go  = !(dlv_hit && !mark_q[pidx_q]) || out_free;

  assign ram_waddr = cnt_slot;
  assign ram_wdata = {req_q.event_class, req_q.event_spec, req_q.handler_addr};

  ect_ram #(
    .Width(RamW),
    .Depth(EVENT_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    slot_d    = slot_q;
    inrange_d = inrange_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    any_d     = any_q;
    status_d  = status_q;
    mark_d    = mark_q;
    ready_d   = ready_q;
    written_d = written_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    ram_we    = 1'b0;
    ram_raddr = slot_q;
    res       = '0;
    res.last  = 1'b1;

    case (state_q)
      S_IDLE: begin
        ram_raddr = in_slot;  // test reads its slot right away
        if (in_accept) begin
          req_d     = in_data_i;
          slot_d    = in_slot;
          inrange_d = in_inrange;
          cnt_d     = '0;
          pend_d    = 1'b0;
          any_d     = 1'b0;
          case (in_data_i.func)
            FUNC_OPEN:    state_d = S_OPEN;
            FUNC_DELIVER: state_d = S_DLV;
            FUNC_TEST:    state_d = S_TEST;
            default:      state_d = S_EXEC;
          endcase
        end
      end

      S_EXEC: begin
        if (out_free) begin
          case (req_q.func)
            FUNC_CLOSE: begin
              if (inrange_q) begin
                status_d[slot_q] = ST_FREE;
              end
            end
            FUNC_ENABLE: begin
              if (inrange_q && status_q[slot_q] == ST_DISABLED) begin
                status_d[slot_q] = ST_ENABLED;
                ready_d[slot_q]  = 1'b0;
              end
            end
            default: ;
          endcase
          out_d     = res;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_OPEN: begin
        if (cnt_q == CW'(EVENT_SLOTS)) begin
          if (out_free) begin
            res.table_full = 1'b1;
            out_d     = res;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (status_q[cnt_slot] == ST_FREE) begin
          if (out_free) begin
            ram_we              = 1'b1;
            status_d[cnt_slot]  = ST_DISABLED;
            mark_d[cnt_slot]    = (req_q.event_mode == MarkMode);
            ready_d[cnt_slot]   = 1'b0;
            written_d[cnt_slot] = 1'b1;
            res.event_handle    = HandleBase | 32'(cnt_q);
            out_d     = res;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_DLV: begin
        if (dlv_go) begin
          if (dlv_hit) begin
            any_d = 1'b1;
            if (mark_q[pidx_q]) begin
              ready_d[pidx_q] = 1'b1;
            end else begin
              res.last         = 1'b0;
              res.call_handler = 1'b1;
              res.handler_out  = ram_rdata[31:0];
              out_d     = res;
              out_vld_d = 1'b1;
            end
          end
          if (cnt_q != CW'(EVENT_SLOTS)) begin
            ram_raddr = cnt_slot;
            pidx_d    = cnt_slot;
            pend_d    = 1'b1;
            cnt_d     = cnt_q + 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = S_DFIN;
          end
        end else begin
          ram_raddr = pidx_q;  // hold the slot until the result slot frees up
        end
      end

      S_DFIN: begin
        if (out_free) begin
          res.delivered = any_q;
          out_d     = res;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_TEST: begin
        if (out_free) begin
          if (inrange_q) begin
            res.ready_flag  = ready_q[slot_q] || class_eq;
            ready_d[slot_q] = 1'b0;
          end
          out_d     = res;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      any_q     <= 1'b0;
      cfg_q     <= AlwaysReadyReset;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        status_q[i] <= ST_FREE;
      end
      mark_q    <= '0;
      ready_q   <= '0;
      written_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      any_q     <= any_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      status_q  <= status_d;
      mark_q    <= mark_d;
      ready_q   <= ready_d;
      written_q <= written_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    slot_q    <= slot_d;
    inrange_q <= inrange_d;
    pidx_q    <= pidx_d;
    out_q     <= out_d;
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("item accepted but sequencer did not leave idle");

  a_handler_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.call_handler |-> !out_q.last)
    else $error("handler result marked last");

  a_handle_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.event_handle != 32'd0 |-> out_q.last && !out_q.table_full)
    else $error("handle together with table full or not last");

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == S_DLV && 32'(pidx_q) < 32'(EVENT_SLOTS))
    else $error("pending slot read outside deliver scan");

  a_open_writes_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_OPEN && status_q[cnt_slot] == ST_FREE)
    else $error("slot written while not free");

endmodule

// ===== dv/event_control_table_tb.sv =====
// Self-checking testbench for the event control table: shadow slot table and result checks.
`timescale 1ns / 1ps

import ect_pkg::*;

class slot_table_shadow;
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_DISABLED = 2'd1,
    SLOT_ENABLED  = 2'd2
  } slot_state_e;

  slot_state_e slot_state   [EventSlotsDef];
  logic [31:0] slot_class   [EventSlotsDef];
  logic [31:0] slot_spec    [EventSlotsDef];
  logic [31:0] slot_handler [EventSlotsDef];
  bit          slot_mark    [EventSlotsDef];
  bit          slot_ready   [EventSlotsDef];
  logic [31:0] ready_class;
  out_item_t   pending_results [$];
  int unsigned mismatches;

  function new();
    ready_class = AlwaysReadyReset;
    mismatches  = 0;
    foreach (slot_state[i]) begin
      slot_state[i]   = SLOT_FREE;
      slot_class[i]   = '0;
      slot_spec[i]    = '0;
      slot_handler[i] = '0;
      slot_mark[i]    = 1'b0;
      slot_ready[i]   = 1'b0;
    end
  endfunction

  // Work out the results one accepted item causes and update the shadow table.
  function void note_op(in_item_t item);
    out_item_t   res;
    out_item_t   call;
    int unsigned sel;
    int unsigned i;
    bit          hit;
    sel = 32'(item.event_ref[SlotSelW-1:0]);
    res = '0;
    res.last = 1'b1;
    case (item.func)
      FUNC_OPEN: begin
        res.table_full = 1'b1;
        for (i = 0; i < EventSlotsDef; i++) begin
          if (res.table_full && slot_state[i] == SLOT_FREE) begin
            slot_state[i]    = SLOT_DISABLED;
            slot_class[i]    = item.event_class;
            slot_spec[i]     = item.event_spec;
            slot_mark[i]     = (item.event_mode == MarkMode);
            slot_handler[i]  = item.handler_addr;
            slot_ready[i]    = 1'b0;
            res.table_full   = 1'b0;
            res.event_handle = HandleBase | 32'(i);
          end
        end
      end
      FUNC_CLOSE: begin
        // only the status goes; class and ready stay behind
        if (sel < EventSlotsDef) slot_state[sel] = SLOT_FREE;
      end
      FUNC_ENABLE: begin
        if (sel < EventSlotsDef && slot_state[sel] == SLOT_DISABLED) begin
          slot_state[sel] = SLOT_ENABLED;
          slot_ready[sel] = 1'b0;
        end
      end
      FUNC_DELIVER: begin
        hit = 1'b0;
        for (i = 0; i < EventSlotsDef; i++) begin
          if (slot_state[i] == SLOT_ENABLED && slot_class[i] == item.event_class &&
              slot_spec[i] == item.event_spec) begin
            hit = 1'b1;
            if (slot_mark[i]) begin
              slot_ready[i] = 1'b1;
            end else begin
              call = '0;
              call.call_handler = 1'b1;
              call.handler_out  = slot_handler[i];
              pending_results.push_back(call);
            end
          end
        end
        res.delivered = hit;
      end
      FUNC_TEST: begin
        if (sel < EventSlotsDef) begin
          res.ready_flag  = slot_ready[sel] || (slot_class[sel] == ready_class);
          slot_ready[sel] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    pending_results.push_back(res);
  endfunction

  function void show(string tag, out_item_t r);
    $display("%s handle=%h full=%b ready=%b call=%b handler=%h delivered=%b last=%b",
             tag, r.event_handle, r.table_full, r.ready_flag, r.call_handler,
             r.handler_out, r.delivered, r.last);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected result at %0t", $time);
        show("  actual  ", got);
      end
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.event_handle !== want.event_handle || got.table_full !== want.table_full ||
        got.ready_flag !== want.ready_flag || got.call_handler !== want.call_handler ||
        got.handler_out !== want.handler_out || got.delivered !== want.delivered ||
        got.last !== want.last) begin
      if (mismatches < 10) begin
        $display("result mismatch at %0t", $time);
        show("  expected", want);
        show("  actual  ", got);
      end
      mismatches++;
    end
  endfunction
endclass

module event_control_table_tb;

  localparam int unsigned NUM_SLOTS      = EventSlotsDef;
  localparam int unsigned MAX_WAIT       = 17;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 60;

  localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;
  localparam logic [31:0] CLASS_A        = 32'h0000_0010;
  localparam logic [31:0] CLASS_B        = 32'h0000_0011;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  slot_table_shadow shadow;

  logic [31:0] cur_ready_class = AlwaysReadyReset;
  bit          hold_req        = 1'b0;
  bit          sender_rush     = 1'b0;
  bit          tx_fast         = 1'b0;
  int unsigned tx_left         = 0;

  always #1 clk_i = ~clk_i;

  event_control_table #(
    .EVENT_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  function automatic logic [31:0] handle_of(int unsigned slot);
    return HandleBase | 32'(slot);
  endfunction

  function automatic in_item_t make_op(logic [2:0] func, logic [31:0] ref_h,
                                       logic [31:0] cls, logic [31:0] spec,
                                       logic [31:0] mode, logic [31:0] hnd);
    in_item_t item;
    item.func         = func;
    item.event_ref    = ref_h;
    item.event_class  = cls;
    item.event_spec   = spec;
    item.event_mode   = mode;
    item.handler_addr = hnd;
    return item;
  endfunction

  // Mostly well-formed traffic: handles of real slots and a small class/spec pool.
  function automatic in_item_t random_op();
    in_item_t    item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      item.func = FUNC_OPEN;
    else if (pick < 35) item.func = FUNC_CLOSE;
    else if (pick < 55) item.func = FUNC_ENABLE;
    else if (pick < 80) item.func = FUNC_DELIVER;
    else if (pick < 96) item.func = FUNC_TEST;
    else                item.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    if ($urandom_range(0, 99) < 85) item.event_ref = handle_of($urandom_range(0, NUM_SLOTS - 1));
    else                            item.event_ref = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: item.event_class = CLASS_A;
      3, 4:    item.event_class = CLASS_B;
      5, 6:    item.event_class = cur_ready_class;
      7:       item.event_class = '0;
      8:       item.event_class = '1;
      default: item.event_class = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: item.event_spec = '0;
      6, 7:             item.event_spec = 32'd1;
      8:                item.event_spec = '1;
      default:          item.event_spec = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: item.event_mode = MarkMode;
      4:          item.event_mode = '0;
      5:          item.event_mode = MarkMode | 32'd1;
      6:          item.event_mode = '1;
      default:    item.event_mode = $urandom;
    endcase
    item.handler_addr = $urandom;
    return item;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic send_op(input in_item_t item);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(8, 30);
    end
    tx_left--;
    gap = (tx_fast || sender_rush) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    shadow.note_op(item);
  endtask

  // Stop sending and wait until every result is in and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ready_class(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.ready_class = value;
    cur_ready_class    = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    bit          rx_fast;
    int unsigned rx_left;
    rx_fast = 1'b0;
    rx_left = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_left == 0) begin
        rx_fast = ($urandom_range(0, 3) == 0);
        rx_left = $urandom_range(8, 30);
      end
      rx_left--;
      hold = rx_fast ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      shadow.check_result(out_data_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    int unsigned k;
    shadow = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the table with a mix of mark and callback slots
    for (i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        0:       send_op(make_op(FUNC_OPEN, '0, CLASS_A, '0, MarkMode, '0));
        1:       send_op(make_op(FUNC_OPEN, '0, CLASS_A, '0, '0, '1));
        2:       send_op(make_op(FUNC_OPEN, '0, AlwaysReadyReset, '1, MarkMode | 32'd1, '0));
        3:       send_op(make_op(FUNC_OPEN, '1, '1, '1, '1, 32'hA5A5_A5A5));
        default: send_op(make_op(FUNC_OPEN, '0, CLASS_A, '0, '0, 32'h8000_0000 | 32'(i)));
      endcase
    end
    send_op(make_op(FUNC_OPEN, '1, '1, '1, '1, '1));            // no slot left
    send_op(make_op(FUNC_ENABLE, handle_of(0), '0, '0, '0, '0));
    send_op(make_op(FUNC_ENABLE, handle_of(1), '0, '0, '0, '0));
    send_op(make_op(FUNC_ENABLE, handle_of(1), '0, '0, '0, '0)); // already enabled
    send_op(make_op(FUNC_DELIVER, '0, CLASS_A, '0, '0, '0));
    send_op(make_op(FUNC_TEST, handle_of(0), '0, '0, '0, '0));
    send_op(make_op(FUNC_CLOSE, 32'h0000_0002, '0, '0, '0, '0));
    send_op(make_op(FUNC_TEST, handle_of(2), '0, '0, '0, '0));   // freed, always-ready class
    send_op(make_op(FUNC_ENABLE, handle_of(2), '0, '0, '0, '0)); // free slot stays free
    send_op(make_op(FUNC_UNUSED_HI, '1, '1, '1, '1, '1));

    for (p = 0; p < 4; p++) begin
      settle();
      case (p)
        0:       write_ready_class('0);
        1:       write_ready_class('1);
        2:       write_ready_class(CLASS_A);
        default: write_ready_class($urandom);
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 5) begin
          hold_req    = 1'b1;
          sender_rush = 1'b1;
        end
        if (p == 1 && k == 35) sender_rush = 1'b0;
        if (p == 2 && k == 30) settle();
        send_op(random_op());
      end
    end
    settle();

    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
